// ===== sv/radix_string_to_integer_unit_assert.svh =====
// assertion macros for the radix string to integer unit checker
// no dependencies; included by the checker file
`ifndef RADIX_STRING_TO_INTEGER_UNIT_ASSERT_SVH
`define RADIX_STRING_TO_INTEGER_UNIT_ASSERT_SVH

// property checked outside reset
`define RSTI_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define RSTI_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rsti_pkg.sv =====
// shared types, constants and helpers for the radix string to integer unit
// no dependencies
`default_nettype none

package rsti_pkg;

   localparam int MAX_SYMBOLS_DEFAULT = 16;
   localparam int VALUE_BITS_DEFAULT  = 32;

   // alphabet storage is fixed at two 64-bit registers
   localparam int SYMBOL_CAP = 16;
   localparam int LEN_W      = 5;
   localparam int IDX_W      = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_CR       = 8'h0d;
   localparam logic [7:0] CHAR_MINUS    = 8'h2d;
   localparam logic [7:0] CHAR_PLUS     = 8'h2b;
   localparam logic [7:0] CHAR_NUL      = 8'h00;

   typedef enum logic [0:0] {
      CSR_SYMBOLS_LOW  = 1'b0,
      CSR_SYMBOLS_HIGH = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_SPACE  = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] index;
      logic [LEN_W-1:0] length;
      logic             invalid;
   } alpha_info_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

endpackage

`default_nettype wire

// ===== sv/radix_string_to_integer_unit.sv =====
// radix string to integer unit: byte stream in, one parsed integer per string out
// depends on rsti_pkg, rsti_alphabet and rsti_parser
//
// usage:
//   req channel: one text byte per item with req_end_of_text marking the
//   last byte of a string. rsp channel: one item per string, issued for the
//   byte marked last, carrying the parsed value and the alphabet flag.
//   csr channel: index 0 writes digit symbols 0..7, index 1 symbols 8..15;
//   csr_ready is always high. write it only while no string is in progress.
//   the result is registered into the output queue when its last byte is taken.
//   throughput: one byte per cycle while req_stall is low; the loop that
//   sets it is the digit multiply-add (accumulator times alphabet length
//   plus digit index), which is combinational on the accumulator register.
//   a two-entry output queue holds results; req_stall rises only when both
//   entries are full, so a stalled receiver holds back the input after two
//   results wait. payloads on rsp hold while rsp_stall is high.
//   reset clears the parse state, the queue and the alphabet; an empty
//   alphabet is flagged invalid until two or more symbols are written.
`default_nettype none

module radix_string_to_integer_unit #(
   parameter int MAX_SYMBOLS = rsti_pkg::MAX_SYMBOLS_DEFAULT,
   parameter int VALUE_BITS  = rsti_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [7:0]                      req_text_byte,
   input  wire logic                            req_end_of_text,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [VALUE_BITS-1:0]         rsp_parsed_value,
   output logic                                 rsp_alphabet_invalid,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [0:0]                      csr_index,
   input  wire logic [rsti_pkg::CSR_DATA_W-1:0] csr_data
);
   import rsti_pkg::*;

   alpha_info_type               info;
   logic                         accept;
   logic                         push;
   logic                         pop;
   logic signed [VALUE_BITS-1:0] new_value;
   logic                         new_invalid;

   logic [1:0]                   count_ff;
   logic [1:0]                   count_in;
   logic signed [VALUE_BITS-1:0] head_value_ff;
   logic                         head_invalid_ff;
   logic signed [VALUE_BITS-1:0] skid_value_ff;
   logic                         skid_invalid_ff;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (count_ff == 2'd2);
   assign pop       = rsp_valid && !rsp_stall;

   rsti_alphabet #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_alphabet (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .text_byte (req_text_byte),
      .info      (info)
   );

   rsti_parser #(.VALUE_BITS(VALUE_BITS)) u_parser (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .text_byte      (req_text_byte),
      .end_of_text    (req_end_of_text),
      .info           (info),
      .result_push    (push),
      .result_value   (new_value),
      .result_invalid (new_invalid)
   );

   always_comb begin
      count_in = count_ff;
      if (push && !pop)      count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (count_ff == 2'd2) begin
         if (pop) begin
            head_value_ff   <= skid_value_ff;
            head_invalid_ff <= skid_invalid_ff;
         end
      end else if (push) begin
         if ((count_ff == 2'd0) || pop) begin
            head_value_ff   <= new_value;
            head_invalid_ff <= new_invalid;
         end else begin
            skid_value_ff   <= new_value;
            skid_invalid_ff <= new_invalid;
         end
      end
   end

   assign rsp_valid            = (count_ff != 2'd0);
   assign rsp_parsed_value     = head_value_ff;
   assign rsp_alphabet_invalid = head_invalid_ff;

endmodule

`default_nettype wire

// ===== sv/rsti_alphabet.sv =====
// digit alphabet registers, length, validity check and digit lookup
// depends on rsti_pkg
`default_nettype none

module rsti_alphabet #(
   parameter int MAX_SYMBOLS = rsti_pkg::MAX_SYMBOLS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write,
   input  wire logic [0:0]                      csr_index,
   input  wire logic [rsti_pkg::CSR_DATA_W-1:0] csr_data,
   input  wire logic [7:0]                      text_byte,
   output rsti_pkg::alpha_info_type             info
);
   import rsti_pkg::*;

   logic [CSR_DATA_W-1:0] symbols_low_ff;
   logic [CSR_DATA_W-1:0] symbols_high_ff;
   logic                  invalid;
   logic [SYMBOL_CAP-1:0][7:0] syms;
   logic [LEN_W-1:0]      length;
   logic                  hit;
   logic [IDX_W-1:0]      index;

   assign syms = {symbols_high_ff, symbols_low_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_SYMBOLS_LOW:  symbols_low_ff  <= csr_data;
               CSR_SYMBOLS_HIGH: symbols_high_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // alphabet ends at the first zero byte
   always_comb begin
      length = LEN_W'(MAX_SYMBOLS);
      for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
         if (syms[i] == CHAR_NUL) length = LEN_W'(i);
      end
   end

   // lowest matching position wins
   always_comb begin
      hit   = 1'b0;
      index = '0;
      for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
         if ((syms[i] == text_byte) && (LEN_W'(i) < length)) begin
            hit   = 1'b1;
            index = IDX_W'(i);
         end
      end
   end

   // judged on the alphabet as it stands in this cycle
   always_comb begin
      invalid = (length < LEN_W'(2));
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if (LEN_W'(i) < length) begin
            if ((syms[i] == CHAR_PLUS) || (syms[i] == CHAR_MINUS) || is_space(syms[i]))
               invalid = 1'b1;
            for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
               if ((LEN_W'(j) < length) && (syms[j] == syms[i])) invalid = 1'b1;
            end
         end
      end
   end

   assign info.hit     = hit;
   assign info.index   = index;
   assign info.length  = length;
   assign info.invalid = invalid;

endmodule

`default_nettype wire

// ===== sv/rsti_parser.sv =====
// parse state machine: whitespace skip, sign run, digit accumulation
// depends on rsti_pkg and the lookup from rsti_alphabet
`default_nettype none

module rsti_parser #(
   parameter int VALUE_BITS = rsti_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [7:0]               text_byte,
   input  wire logic                     end_of_text,
   input  wire rsti_pkg::alpha_info_type info,
   output logic                          result_push,
   output logic signed [VALUE_BITS-1:0]  result_value,
   output logic                          result_invalid
);
   import rsti_pkg::*;

   phase_type             phase_ff;
   phase_type             phase_in;
   logic                  negative_ff;
   logic                  negative_in;
   logic [VALUE_BITS-1:0] acc_ff;
   logic [VALUE_BITS-1:0] acc_in;
   logic [VALUE_BITS-1:0] scaled;
   logic [VALUE_BITS-1:0] magnitude;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SPACE;
         negative_ff <= 1'b0;
         acc_ff      <= '0;
      end else if (accept) begin
         if (end_of_text) begin
            phase_ff    <= PH_SPACE;
            negative_ff <= 1'b0;
            acc_ff      <= '0;
         end else begin
            phase_ff    <= phase_in;
            negative_ff <= negative_in;
            acc_ff      <= acc_in;
         end
      end
   end

   assign scaled = acc_ff * {{(VALUE_BITS - LEN_W){1'b0}}, info.length}
                 + {{(VALUE_BITS - IDX_W){1'b0}}, info.index};

   always_comb begin
      phase_in    = phase_ff;
      negative_in = negative_ff;
      acc_in      = acc_ff;
      if ((phase_in == PH_SPACE) && !is_space(text_byte)) phase_in = PH_SIGN;
      if (phase_in == PH_SIGN) begin
         if (info.hit) begin
            phase_in = PH_DIGITS;
         end else if (text_byte == CHAR_MINUS) begin
            negative_in = !negative_ff;
         end else if (text_byte != CHAR_PLUS) begin
            // stray byte in the sign run pins the result at zero
            negative_in = 1'b0;
            acc_in      = '0;
            phase_in    = PH_DONE;
         end
      end
      if (phase_in == PH_DIGITS) begin
         if (info.hit) acc_in = scaled;
         else          phase_in = PH_DONE;
      end
   end

   assign magnitude = negative_in ? (~acc_in + 1'b1) : acc_in;

   always_comb begin
      result_push    = accept && end_of_text;
      result_invalid = info.invalid;
      if (!info.invalid && ((phase_in == PH_DIGITS) || (phase_in == PH_DONE)))
         result_value = magnitude;
      else
         result_value = '0;
   end

endmodule

`default_nettype wire

// ===== sv/rsti_checker.sv =====
// port-level assertions for radix_string_to_integer_unit, bound to the top level
// depends on rsti_pkg and radix_string_to_integer_unit_assert.svh
`default_nettype none

`include "radix_string_to_integer_unit_assert.svh"

module rsti_checker #(
   parameter int VALUE_BITS = rsti_pkg::VALUE_BITS_DEFAULT
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic                            req_end_of_text,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic signed [VALUE_BITS-1:0]    rsp_parsed_value,
   input wire logic                            rsp_alphabet_invalid
);

   // a rejected alphabet always reports zero
   `RSTI_ASSERT(a_invalid_zero, clock, reset, rsp_valid && rsp_alphabet_invalid |-> rsp_parsed_value == 0, "rejected alphabet gave a nonzero value")

   // a result appears only after a last byte was taken
   `RSTI_ASSERT(a_rsp_from_last, clock, reset, $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_end_of_text), "result without a last byte")

   // input backs up only behind a waiting result
   `RSTI_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_valid, "input stalled with no result pending")

   // reset empties the result queue
   `RSTI_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid right after reset")

   // a stalled result holds
   `RSTI_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_parsed_value) && $stable(rsp_alphabet_invalid), "stalled result changed")

endmodule

bind radix_string_to_integer_unit rsti_checker #(.VALUE_BITS(VALUE_BITS)) u_rsti_checker (.*);

`default_nettype wire
